@@ rtl/utf8_url_slug_filter_defines.svh @@
// ---------------------------------------------------------------------------
// utf8_url_slug_filter_defines
// Assertion macros shared by the slug filter RTL.
// ---------------------------------------------------------------------------
`ifndef UTF8_URL_SLUG_FILTER_DEFINES_SVH
`define UTF8_URL_SLUG_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define USF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define USF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/usf_pkg.sv @@
// ---------------------------------------------------------------------------
// usf_pkg
// Types, byte codes and decision functions of the URL slug filter.
// ---------------------------------------------------------------------------
`default_nettype none

package usf_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned REG_INDEX_W = 2;
    localparam int unsigned REG_DATA_W  = 2;

    // Register indexes
    localparam logic [REG_INDEX_W-1:0] REG_SANITIZE_ENABLE = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_SEPARATOR_MODE  = 2'd1;

    // Separator modes
    localparam logic [1:0] SEP_DASH       = 2'd0;
    localparam logic [1:0] SEP_NONE       = 2'd1;
    localparam logic [1:0] SEP_UNDERSCORE = 2'd2;
    localparam logic [1:0] SEP_SPACE      = 2'd3;

    typedef logic [7:0] byte_t;

    // ASCII codes
    localparam byte_t CH_SPACE  = 8'h20;
    localparam byte_t CH_QUOTE  = 8'h22;
    localparam byte_t CH_APOS   = 8'h27;
    localparam byte_t CH_GRAVE  = 8'h60;
    localparam byte_t CH_DASH   = 8'h2D;
    localparam byte_t CH_USCORE = 8'h5F;
    localparam byte_t CH_DOT    = 8'h2E;
    localparam byte_t CH_SLASH  = 8'h2F;
    localparam byte_t CH_0      = 8'h30;
    localparam byte_t CH_9      = 8'h39;
    localparam byte_t CH_UA     = 8'h41;
    localparam byte_t CH_UZ     = 8'h5A;
    localparam byte_t CH_A      = 8'h61;
    localparam byte_t CH_E      = 8'h65;
    localparam byte_t CH_S      = 8'h73;
    localparam byte_t CH_Z      = 8'h7A;
    localparam byte_t CASE_GAP  = 8'h20;
    localparam byte_t NUL       = 8'h00;

    // UTF-8 codes
    localparam byte_t LEAD_C2    = 8'hC2;
    localparam byte_t ACUTE      = 8'hB4;
    localparam byte_t LEAD_E2    = 8'hE2;
    localparam byte_t PUNCT_80   = 8'h80;
    localparam byte_t LSQUOTE    = 8'h98;
    localparam byte_t RSQUOTE    = 8'h99;
    localparam byte_t LDQUOTE    = 8'h9C;
    localparam byte_t RDQUOTE    = 8'h9D;
    localparam byte_t LEAD_CC    = 8'hCC;
    localparam byte_t LEAD_CD    = 8'hCD;
    localparam byte_t CD_LAST    = 8'hAF;
    localparam byte_t LEAD_C3    = 8'hC3;
    localparam byte_t AE_UPPER   = 8'h86;
    localparam byte_t AE_LOWER   = 8'hA6;
    localparam byte_t SHARP_S    = 8'h9F;
    localparam byte_t CONT_FIRST = 8'h80;
    localparam byte_t CONT_LAST  = 8'hBF;

    // ASCII base of C3 80..C3 BF, zero where there is none
    localparam byte_t FOLD_TABLE [64] = '{
        8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h00, 8'h63,
        8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
        8'h64, 8'h6E, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h00,
        8'h6F, 8'h75, 8'h75, 8'h75, 8'h75, 8'h79, 8'h00, 8'h00,
        8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h00, 8'h63,
        8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
        8'h64, 8'h6E, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h00,
        8'h6F, 8'h75, 8'h75, 8'h75, 8'h75, 8'h79, 8'h00, 8'h79
    };

    // Filter state carried from byte to byte
    typedef struct packed {
        byte_t      la0;
        byte_t      la1;
        logic [1:0] la_count;
        logic       last_sep;
        logic       pending;
    } usf_state_t;

    // Results of one input byte, handed to the output buffer
    typedef struct packed {
        byte_t [3:0] bytes;
        logic [2:0]  count;
        logic        bvalid;
        logic        last;
    } usf_result_t;

    // Outcome of deciding one front byte
    typedef struct packed {
        logic [1:0]  used;
        logic [1:0]  nb;
        byte_t [2:0] bytes;
        logic        last_sep;
        logic        pending;
    } usf_dec_t;

    function automatic byte_t usf_sep_byte(input logic [1:0] mode);
        byte_t s;
        case (mode)
            SEP_DASH:       s = CH_DASH;
            SEP_NONE:       s = NUL;
            SEP_UNDERSCORE: s = CH_USCORE;
            default:        s = CH_SPACE;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] usf_need(input byte_t c, input logic san);
        logic [1:0] need;
        need = 2'd0;
        if (san) begin
            if (c == LEAD_E2) begin
                need = 2'd2;
            end
            else if (c inside {LEAD_C2, LEAD_C3, LEAD_CC, LEAD_CD}) begin
                need = 2'd1;
            end
        end
        return need;
    endfunction

    function automatic byte_t usf_lower(input byte_t c);
        byte_t r;
        r = c;
        if (c inside {[CH_UA:CH_UZ]}) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

    function automatic logic usf_is_slug(input byte_t c);
        return (c inside {[CH_A:CH_Z], [CH_0:CH_9], CH_SLASH, CH_DOT});
    endfunction

    // Decide the front byte c with followers b1, b2 (n bytes present).
    function automatic usf_dec_t usf_decide(
        input byte_t      c,
        input byte_t      b1,
        input byte_t      b2,
        input logic [1:0] n,
        input logic       san,
        input logic [1:0] mode,
        input logic       last_sep,
        input logic       pending
    );
        usf_dec_t d;
        byte_t    sep;
        byte_t    ch0;
        byte_t    ch1;
        byte_t    base;
        byte_t    low;
        logic     two;
        logic     do_send;
        logic     do_sep;
        d          = '0;
        d.used     = 2'd1;
        d.last_sep = last_sep;
        d.pending  = pending;
        sep        = usf_sep_byte(mode);
        ch0        = NUL;
        ch1        = NUL;
        base       = NUL;
        two        = 1'b0;
        do_send    = 1'b0;
        do_sep     = 1'b0;
        low        = usf_lower(c);
        if (!san) begin
            if (c == CH_SPACE) begin
                if (sep != NUL) begin
                    d.bytes[0] = sep;
                    d.nb       = 2'd1;
                end
            end
            else begin
                d.bytes[0] = c;
                d.nb       = 2'd1;
            end
        end
        else if (c inside {CH_APOS, CH_QUOTE, CH_GRAVE}) begin
            d.used = 2'd1;
        end
        else if (c == LEAD_C2 && n >= 2'd2 && b1 == ACUTE) begin
            d.used = 2'd2;
        end
        else if (c == LEAD_E2 && n == 2'd3 && b1 == PUNCT_80 &&
                 (b2 inside {LSQUOTE, RSQUOTE, LDQUOTE, RDQUOTE})) begin
            d.used = 2'd3;
        end
        else if (c == LEAD_CC && n >= 2'd2 && (b1 inside {[CONT_FIRST:CONT_LAST]})) begin
            d.used = 2'd2;
        end
        else if (c == LEAD_CD && n >= 2'd2 && (b1 inside {[CONT_FIRST:CD_LAST]})) begin
            d.used = 2'd2;
        end
        else if (c == LEAD_C3 && n >= 2'd2) begin
            d.used = 2'd2;
            if (b1 == AE_UPPER || b1 == AE_LOWER) begin
                do_send = 1'b1;
                ch0     = CH_A;
                ch1     = CH_E;
                two     = 1'b1;
            end
            else if (b1 == SHARP_S) begin
                do_send = 1'b1;
                ch0     = CH_S;
                ch1     = CH_S;
                two     = 1'b1;
            end
            else begin
                if (b1 inside {[CONT_FIRST:CONT_LAST]}) begin
                    base = FOLD_TABLE[b1[5:0]];
                end
                if (base != NUL) begin
                    do_send = 1'b1;
                    ch0     = base;
                end
                else begin
                    do_sep = 1'b1;
                end
            end
        end
        else begin
            if (usf_is_slug(low)) begin
                do_send = 1'b1;
                ch0     = low;
            end
            else begin
                do_sep = 1'b1;
            end
        end
        // Send a slug character, preceded by any separator still owed
        if (do_send) begin
            if (d.pending && sep != NUL) begin
                d.bytes[d.nb] = sep;
                d.nb          = d.nb + 2'd1;
            end
            d.pending     = 1'b0;
            d.bytes[d.nb] = ch0;
            d.nb          = d.nb + 2'd1;
            if (two) begin
                d.bytes[d.nb] = ch1;
                d.nb          = d.nb + 2'd1;
            end
            d.last_sep = 1'b0;
        end
        // Owe one separator unless the previous output already was one
        if (do_sep && sep != NUL && !d.last_sep) begin
            d.pending  = 1'b1;
            d.last_sep = 1'b1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/usf_in_if.sv @@
// ---------------------------------------------------------------------------
// usf_in_if
// Valid/ready channel carrying the bytes of a page name.
// ---------------------------------------------------------------------------
`default_nettype none

interface usf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       name_end;

    modport source (output valid, output in_byte, output name_end, input ready);
    modport sink   (input valid, input in_byte, input name_end, output ready);
endinterface

`default_nettype wire

@@ rtl/usf_out_if.sv @@
// ---------------------------------------------------------------------------
// usf_out_if
// Valid/ready channel carrying the bytes of a slug.
// ---------------------------------------------------------------------------
`default_nettype none

interface usf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       slug_end;

    modport source (output valid, output out_byte, output byte_valid, output slug_end,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input slug_end,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/usf_decode.sv @@
// ---------------------------------------------------------------------------
// usf_decode
// Decides every byte of the lookahead window that can be decided and
// collects the slug bytes and the next filter state.
// ---------------------------------------------------------------------------
`default_nettype none

module usf_decode import usf_pkg::*; (
    input  var usf_state_t  st,
    input  var byte_t       in_byte,
    input  wire             name_end,
    input  wire             san,
    input  wire [1:0]       mode,
    output usf_state_t      nxt,
    output usf_result_t     res
);

    function automatic byte_t pick(input byte_t [2:0] w, input logic [2:0] idx);
        byte_t r;
        case (idx)
            3'd0:    r = w[0];
            3'd1:    r = w[1];
            3'd2:    r = w[2];
            default: r = NUL;
        endcase
        return r;
    endfunction

    byte_t [2:0] work;
    byte_t [3:0] obuf;
    logic [1:0]  n;
    logic [1:0]  pos;
    logic [1:0]  rem;
    logic [1:0]  held;
    logic [2:0]  cnt;
    logic        stop;
    logic        ls;
    logic        pd;
    byte_t       c;
    byte_t       b1;
    byte_t       b2;
    usf_dec_t    d;

    always_comb
    begin
        // Window: held bytes first, then the new byte
        work[0] = (st.la_count == 2'd0) ? in_byte : st.la0;
        work[1] = (st.la_count == 2'd1) ? in_byte : st.la1;
        work[2] = in_byte;
        n       = st.la_count + 2'd1;
        pos     = 2'd0;
        rem     = 2'd0;
        cnt     = 3'd0;
        stop    = 1'b0;
        ls      = st.last_sep;
        pd      = st.pending;
        obuf    = '0;
        c       = NUL;
        b1      = NUL;
        b2      = NUL;
        d       = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (!stop && pos < n)
            begin
                rem = n - pos;
                c   = pick(work, {1'b0, pos});
                b1  = (rem >= 2'd2) ? pick(work, {1'b0, pos} + 3'd1) : NUL;
                b2  = (rem == 2'd3) ? pick(work, {1'b0, pos} + 3'd2) : NUL;
                if (!name_end && (rem - 2'd1) < usf_need(c, san))
                begin
                    stop = 1'b1;
                end
                else
                begin
                    d = usf_decide(c, b1, b2, rem, san, mode, ls, pd);
                    for (int j = 0; j < 3; j++)
                    begin
                        if (2'(j) < d.nb && cnt < 3'(MAX_RESULTS))
                        begin
                            obuf[cnt[1:0]] = d.bytes[j];
                            cnt            = cnt + 3'd1;
                        end
                    end
                    pos = pos + d.used;
                    ls  = d.last_sep;
                    pd  = d.pending;
                end
            end
        end
        held         = n - pos;
        nxt.la0      = pick(work, {1'b0, pos});
        nxt.la1      = pick(work, {1'b0, pos} + 3'd1);
        nxt.la_count = name_end ? 2'd0 : held;
        nxt.last_sep = name_end ? 1'b1 : ls;
        nxt.pending  = name_end ? 1'b0 : pd;

        res.bytes = obuf;
        res.last  = name_end;
        if (name_end && cnt == 3'd0)
        begin
            res.count  = 3'd1;
            res.bvalid = 1'b0;
        end
        else
        begin
            res.count  = cnt;
            res.bvalid = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/usf_out_buf.sv @@
// ---------------------------------------------------------------------------
// usf_out_buf
// Holds the results of one input byte and hands them out one per transfer.
// ---------------------------------------------------------------------------
`default_nettype none
`include "utf8_url_slug_filter_defines.svh"

module usf_out_buf import usf_pkg::*; (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             load,
    input  var usf_result_t res,
    output logic            free,
    usf_out_if.source       slug
);

    byte_t [3:0] data_reg;
    logic [2:0]  left_reg;
    logic [1:0]  rd_reg;
    logic        bvalid_reg;
    logic        last_reg;
    logic        drain;

    assign drain = slug.valid && slug.ready;
    // Free when empty, or once the final held result leaves in this cycle
    assign free  = (left_reg == 3'd0) || (left_reg == 3'd1 && slug.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 3'd0;
            rd_reg   <= 2'd0;
        end
        else if (load)
        begin
            left_reg <= res.count;
            rd_reg   <= 2'd0;
        end
        else if (drain)
        begin
            left_reg <= left_reg - 3'd1;
            rd_reg   <= rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg   <= res.bytes;
            bvalid_reg <= res.bvalid;
            last_reg   <= res.last;
        end
    end

    assign slug.valid      = (left_reg != 3'd0);
    assign slug.out_byte   = data_reg[rd_reg];
    assign slug.byte_valid = bvalid_reg;
    assign slug.slug_end   = last_reg && (left_reg == 3'd1);

    `USF_ASSERT_NOW(a_load_when_free, load, free, "results loaded over undelivered ones")
    `USF_ASSERT_NOW(a_empty_item_alone, slug.valid && !slug.byte_valid,
                    slug.slug_end && left_reg == 3'd1, "empty result is not the sole end item")

endmodule

`default_nettype wire

@@ rtl/utf8_url_slug_filter.sv @@
// ---------------------------------------------------------------------------
// utf8_url_slug_filter
// Streams the UTF-8 bytes of a page name in and its URL slug bytes out.
// ---------------------------------------------------------------------------
// The filter takes one name byte per cycle while its output buffer can take
// the results, and gives the slug bytes it causes one per output transfer. A
// byte is registered on input, then decided with up to two held lookahead
// bytes once the output buffer is free; its results are then registered in
// a four-entry output buffer. A byte that causes k results holds the buffer
// until k transfers have left, so the sustained rate is one byte per cycle
// only while no byte yields more than one result and the slug side is ready;
// the single-result drain of the output buffer sets that limit. Bytes that
// only enter the lookahead give no result. The final byte of a name (name_end)
// always gives at least one result: the last one carries slug_end, and if
// the name leaves nothing to send a lone item with byte_valid low marks the
// end. There is no clearing pass after reset. Write the two configuration
// registers (index 0 sanitize_enable, index 1 separator_mode) only while no
// name byte is in flight.
// ---------------------------------------------------------------------------
`default_nettype none
`include "utf8_url_slug_filter_defines.svh"

module utf8_url_slug_filter import usf_pkg::*; (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   wr_en,
    input  wire [REG_INDEX_W-1:0] wr_index,
    input  wire [REG_DATA_W-1:0]  wr_data,
    usf_in_if.sink                name_bytes,
    usf_out_if.source             slug_bytes
);

    // Configuration registers
    logic        sanitize_reg;
    logic [1:0]  sep_mode_reg;

    // Input register
    logic        in_valid_reg;
    byte_t       in_byte_reg;
    logic        in_end_reg;

    // Filter state: lookahead bytes are payload, the rest is control
    byte_t       la0_reg;
    byte_t       la1_reg;
    logic [1:0]  la_count_reg;
    logic        last_sep_reg;
    logic        pending_reg;

    usf_state_t  st;
    usf_state_t  st_next;
    usf_result_t res;
    logic        buf_free;
    logic        fire;
    logic        in_take;

    // Decide the held byte when the output buffer can take all its results
    assign fire    = in_valid_reg && buf_free;
    // Accept a new byte whenever the input register is empty or advances
    assign name_bytes.ready = !in_valid_reg || fire;
    assign in_take = name_bytes.valid && name_bytes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sanitize_reg <= 1'b0;
            sep_mode_reg <= SEP_DASH;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SANITIZE_ENABLE: sanitize_reg <= wr_data[0];
                REG_SEPARATOR_MODE:  sep_mode_reg <= wr_data[1:0];
                default:             ;
            endcase
        end
    end

    // Hold or advance the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= name_bytes.in_byte;
            in_end_reg  <= name_bytes.name_end;
        end
    end

    // Advance the filter state on every decided byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_count_reg <= 2'd0;
            last_sep_reg <= 1'b1;
            pending_reg  <= 1'b0;
        end
        else if (fire)
        begin
            la_count_reg <= st_next.la_count;
            last_sep_reg <= st_next.last_sep;
            pending_reg  <= st_next.pending;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            la0_reg <= st_next.la0;
            la1_reg <= st_next.la1;
        end
    end

    assign st.la0      = la0_reg;
    assign st.la1      = la1_reg;
    assign st.la_count = la_count_reg;
    assign st.last_sep = last_sep_reg;
    assign st.pending  = pending_reg;

    usf_decode u_decode (
        .st       (st),
        .in_byte  (in_byte_reg),
        .name_end (in_end_reg),
        .san      (sanitize_reg),
        .mode     (sep_mode_reg),
        .nxt      (st_next),
        .res      (res)
    );

    usf_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire),
        .res   (res),
        .free  (buf_free),
        .slug  (slug_bytes)
    );

    `USF_ASSERT_NOW(a_pending_marks_sep, pending_reg, last_sep_reg,
                    "separator owed without separator flag")
    `USF_ASSERT_NOW(a_lookahead_depth, 1'b1, la_count_reg != 2'd3,
                    "lookahead holds more than two bytes")
    `USF_ASSERT_NEXT(a_end_restores, fire && in_end_reg,
                     la_count_reg == 2'd0 && last_sep_reg && !pending_reg,
                     "state not restored after end of name")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to URL slug filter. Page names go in one
// byte per transfer; an in-bench slug predictor keeps its own lookahead,
// separator flags and register copies and queues the slug transfers each
// accepted byte should cause. Every slug transfer is checked in order, field
// by field, with random idling on both channels in all but the last test.
// ---------------------------------------------------------------------------

module tb import usf_pkg::*; ();

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int FLUSH_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
    localparam int REPORT_LIMIT   = 10;

    // Indexes that map to no register; writes there must change nothing
    localparam logic [REG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [REG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        byte_t ch;
        logic  vld;
        logic  fin;
    } slug_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   wr_en;
    logic [REG_INDEX_W-1:0] wr_index;
    logic [REG_DATA_W-1:0]  wr_data;

    usf_in_if  name_if ();
    usf_out_if slug_if ();

    utf8_url_slug_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .name_bytes (name_if),
        .slug_bytes (slug_if)
    );

    always #(CLK_HALF) clk = ~clk;

    // -----------------------------------------------------------------------
    // Slug predictor state: register copies, held lookahead, separator flags
    // -----------------------------------------------------------------------
    logic       cfg_san;
    logic [1:0] cfg_mode;
    byte_t      held_bytes [2];
    int         held_count;
    logic       prev_was_sep;
    logic       sep_owed;
    byte_t      step_bytes [$];       // slug bytes produced by the current name byte
    slug_item_t exp_slug_q [$];       // slug transfers still to arrive, oldest first

    byte_t      name_q [$];           // page name being sent
    slug_item_t want_item;
    logic       idle_on;
    int         ready_hold;
    int         quiet_cycles;
    int         mismatches;
    int         bytes_sent;
    int         names_sent;
    int         slugs_checked;
    int         reg_writes;

    // Separator character under the current mode; NUL means drop it
    function automatic byte_t sep_char();
        case (cfg_mode)
            SEP_DASH:       return CH_DASH;
            SEP_NONE:       return NUL;
            SEP_UNDERSCORE: return CH_USCORE;
            default:        return CH_SPACE;
        endcase
    endfunction

    // A step never yields more than four slug bytes
    function automatic void put_slug_byte(byte_t b);
        if (step_bytes.size() < MAX_RESULTS)
            step_bytes.push_back(b);
    endfunction

    // Emit a slug character, flushing an owed separator ahead of it
    function automatic void emit_char(byte_t c);
        if (sep_owed) begin
            if (sep_char() != NUL)
                put_slug_byte(sep_char());
            sep_owed = 1'b0;
        end
        put_slug_byte(c);
        prev_was_sep = 1'b0;
    endfunction

    // Owe one separator unless the previous output already was one
    function automatic void owe_separator();
        if (sep_char() != NUL && !prev_was_sep) begin
            sep_owed     = 1'b1;
            prev_was_sep = 1'b1;
        end
    endfunction

    function automatic void ascii_rule(byte_t c);
        byte_t low;
        low = (c >= CH_UA && c <= CH_UZ) ? byte_t'(c + 8'd32) : c;
        if ((low >= "a" && low <= "z") || (low >= "0" && low <= "9") ||
            low == "/" || low == ".")
            emit_char(low);
        else
            owe_separator();
    endfunction

    // ASCII base letter of the Latin-1 character C3 <cont>, NUL if none
    function automatic byte_t latin1_base(byte_t cont);
        case (cont[4:0])
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: return "a";
            5'd7:                               return "c";
            5'd8, 5'd9, 5'd10, 5'd11:           return "e";
            5'd12, 5'd13, 5'd14, 5'd15:         return "i";
            5'd16:                              return "d";
            5'd17:                              return "n";
            5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
            5'd24:                              return "o";
            5'd25, 5'd26, 5'd27, 5'd28:         return "u";
            5'd29:                              return "y";
            5'd31:                              return cont[5] ? "y" : NUL;
            default:                            return NUL;
        endcase
    endfunction

    // Continuation bytes a lead byte waits for before it is decided
    function automatic int bytes_wanted(byte_t c);
        if (!cfg_san)
            return 0;
        if (c == LEAD_E2)
            return 2;
        if (c == LEAD_C2 || c == LEAD_C3 || c == LEAD_CC || c == LEAD_CD)
            return 1;
        return 0;
    endfunction

    // Decide front byte c with followers b1, b2; n bytes present. Returns bytes used.
    function automatic int decide_front(byte_t c, byte_t b1, byte_t b2, int n);
        byte_t base;
        if (!cfg_san) begin
            if (c != CH_SPACE)
                put_slug_byte(c);
            else if (sep_char() != NUL)
                put_slug_byte(sep_char());
            return 1;
        end
        if (c == CH_APOS || c == CH_QUOTE || c == CH_GRAVE)
            return 1;
        if (c == LEAD_C2 && n >= 2 && b1 == ACUTE)
            return 2;
        if (c == LEAD_E2 && n >= 3 && b1 == PUNCT_80 &&
            (b2 == LSQUOTE || b2 == RSQUOTE || b2 == LDQUOTE || b2 == RDQUOTE))
            return 3;
        if (c == LEAD_CC && n >= 2 && b1 >= CONT_FIRST && b1 <= CONT_LAST)
            return 2;
        if (c == LEAD_CD && n >= 2 && b1 >= CONT_FIRST && b1 <= CD_LAST)
            return 2;
        if (c == LEAD_C3 && n >= 2) begin
            if (b1 == AE_UPPER || b1 == AE_LOWER) begin
                emit_char("a");
                emit_char("e");
                return 2;
            end
            if (b1 == SHARP_S) begin
                emit_char("s");
                emit_char("s");
                return 2;
            end
            base = (b1 >= CONT_FIRST && b1 <= CONT_LAST) ? latin1_base(b1) : NUL;
            // Both bytes go, even when the follower is plain ASCII
            if (base != NUL)
                ascii_rule(base);
            else
                owe_separator();
            return 2;
        end
        ascii_rule(c);
        return 1;
    endfunction

    // Run one accepted name byte through the predictor and queue its slug transfers
    function automatic void predict_slug(byte_t b, logic last);
        byte_t      win [3];
        int         n;
        int         pos;
        int         k;
        slug_item_t item;
        n = 0;
        for (k = 0; k < held_count; k++) begin
            win[n] = held_bytes[k];
            n++;
        end
        win[n] = b;
        n++;
        pos = 0;
        step_bytes.delete();
        while (pos < n) begin
            if (!last && (n - pos - 1) < bytes_wanted(win[pos]))
                break;
            pos += decide_front(win[pos],
                                (pos + 1 < n) ? win[pos + 1] : NUL,
                                (pos + 2 < n) ? win[pos + 2] : NUL,
                                n - pos);
        end
        held_count = (n - pos > 2) ? 2 : n - pos;
        for (k = 0; k < held_count; k++)
            held_bytes[k] = win[pos + k];
        if (last) begin
            // End of name: drop the trailing separator and start afresh
            held_count   = 0;
            sep_owed     = 1'b0;
            prev_was_sep = 1'b1;
            if (step_bytes.size() == 0) begin
                item = '{ch: NUL, vld: 1'b0, fin: 1'b1};
                exp_slug_q.push_back(item);
                return;
            end
        end
        for (k = 0; k < step_bytes.size(); k++) begin
            item = '{ch: step_bytes[k], vld: 1'b1,
                     fin: last && (k == step_bytes.size() - 1)};
            exp_slug_q.push_back(item);
        end
    endfunction

    function automatic void flag_mismatch(string why);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("tb: MISMATCH %s", why);
    endfunction

    // -----------------------------------------------------------------------
    // Slug side: check each transfer against the oldest expectation, then
    // pick the next ready value (random stall bursts of ready-low cycles)
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && slug_if.valid && slug_if.ready) begin
            slugs_checked++;
            if (exp_slug_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected slug transfer: byte %02h valid %0b end %0b",
                                        slug_if.out_byte, slug_if.byte_valid,
                                        slug_if.slug_end));
            end
            else begin
                want_item = exp_slug_q.pop_front();
                if (slug_if.out_byte !== want_item.ch || slug_if.byte_valid !== want_item.vld ||
                    slug_if.slug_end !== want_item.fin)
                    flag_mismatch($sformatf(
                        "slug transfer %0d: expected byte %02h valid %0b end %0b, got %02h %0b %0b",
                        slugs_checked, want_item.ch, want_item.vld, want_item.fin,
                        slug_if.out_byte, slug_if.byte_valid, slug_if.slug_end));
            end
        end

        if (!rst_n) begin
            slug_if.ready <= 1'b0;
        end
        else if (ready_hold != 0) begin
            ready_hold    <= ready_hold - 1;
            slug_if.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_hold    <= $urandom_range(0, 5);
            slug_if.ready <= 1'b0;
        end
        else begin
            slug_if.ready <= 1'b1;
        end
    end

    // Watchdog: give up when neither channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (name_if.valid && name_if.ready) || (slug_if.valid && slug_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired with %0d slug transfers outstanding",
                     exp_slug_q.size());
            $display("tb: errors");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Offer one name byte, optionally after an idle burst; hold until it transfers
    task automatic send_byte(byte_t b, logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            name_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        name_if.valid    <= 1'b1;
        name_if.in_byte  <= b;
        name_if.name_end <= last;
        do
            @(posedge clk);
        while (!name_if.ready);
        predict_slug(b, last);
        bytes_sent++;
    endtask

    task automatic send_name();
        int i;
        for (i = 0; i < name_q.size(); i++)
            send_byte(name_q[i], i == name_q.size() - 1);
        names_sent++;
    endtask

    // Drop valid and wait until every owed slug transfer has come out
    task automatic drain();
        name_if.valid <= 1'b0;
        while (exp_slug_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write at a name boundary, with the block idle
    task automatic set_reg(logic [REG_INDEX_W-1:0] idx, logic [REG_DATA_W-1:0] val);
        drain();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_SANITIZE_ENABLE: cfg_san  = val[0];
            REG_SEPARATOR_MODE:  cfg_mode = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Build a random page name: mostly well-formed UTF-8 and ASCII tokens,
    // with some stray leads, broken sequences and raw bytes mixed in
    task automatic make_name();
        int tokens;
        int t;
        name_q.delete();
        tokens = $urandom_range(1, 7);
        for (t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 15))
                0, 1: name_q.push_back(byte_t'(CH_UA + $urandom_range(0, 25)));
                2, 3: name_q.push_back(byte_t'(CH_A + $urandom_range(0, 25)));
                4:    name_q.push_back(byte_t'(CH_0 + $urandom_range(0, 9)));
                5:    name_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_DOT);
                6: begin
                    case ($urandom_range(0, 2))
                        0:       name_q.push_back(CH_APOS);
                        1:       name_q.push_back(CH_QUOTE);
                        default: name_q.push_back(CH_GRAVE);
                    endcase
                end
                7:    name_q.push_back(byte_t'($urandom_range(8'h20, 8'h7E)));
                8: begin
                    name_q.push_back(LEAD_C2);
                    name_q.push_back($urandom_range(0, 2) != 0 ? ACUTE
                                                               : byte_t'($urandom_range(0, 255)));
                end
                9: begin
                    name_q.push_back(LEAD_E2);
                    if ($urandom_range(0, 3) != 0) begin
                        name_q.push_back(PUNCT_80);
                        case ($urandom_range(0, 3))
                            0:       name_q.push_back(LSQUOTE);
                            1:       name_q.push_back(RSQUOTE);
                            2:       name_q.push_back(LDQUOTE);
                            default: name_q.push_back(RDQUOTE);
                        endcase
                    end
                    else begin
                        name_q.push_back(byte_t'($urandom_range(0, 255)));
                        name_q.push_back(byte_t'($urandom_range(0, 255)));
                    end
                end
                10: begin
                    name_q.push_back($urandom_range(0, 1) ? LEAD_CC : LEAD_CD);
                    name_q.push_back(byte_t'($urandom_range(CONT_FIRST, CONT_LAST)));
                end
                11: begin
                    name_q.push_back(LEAD_C3);
                    name_q.push_back(byte_t'($urandom_range(CONT_FIRST, CONT_LAST)));
                end
                12: begin
                    name_q.push_back(LEAD_C3);
                    case ($urandom_range(0, 2))
                        0:       name_q.push_back(AE_UPPER);
                        1:       name_q.push_back(AE_LOWER);
                        default: name_q.push_back(SHARP_S);
                    endcase
                end
                13:   name_q.push_back(byte_t'($urandom_range(0, 255)));
                14: begin
                    // Lead byte with its continuation missing
                    case ($urandom_range(0, 4))
                        0:       name_q.push_back(LEAD_C2);
                        1:       name_q.push_back(LEAD_C3);
                        2:       name_q.push_back(LEAD_CC);
                        3:       name_q.push_back(LEAD_CD);
                        default: name_q.push_back(LEAD_E2);
                    endcase
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       name_q.push_back(NUL);
                        1:       name_q.push_back(8'hFF);
                        default: name_q.push_back(CH_SPACE);
                    endcase
                end
            endcase
        end
    endtask

    // Send random names until about budget bytes went in; stop on a name boundary
    task automatic run_names(int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            make_name();
            send_name();
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset values: plain mode with dash, so only the space changes
    task automatic test_reset_defaults();
        name_q = '{"A", "b", CH_SPACE, "c"};
        send_name();
    endtask

    // Hand-built names hitting the sanitize rules listed below
    task automatic test_sanitize_directed();
        set_reg(REG_SANITIZE_ENABLE, 2'd1);
        // leading space, capital, quote, acute accent, curly quote, ae
        // ligature, combining mark, separator run, sharp s, Latin-1 letter
        // with no base, slash and dot, NUL, 0xFF, lone C3 at the end
        name_q = '{CH_SPACE, "A", CH_APOS, LEAD_C2, ACUTE, LEAD_E2, PUNCT_80, LDQUOTE,
                   LEAD_C3, AE_UPPER, LEAD_CC, 8'h81, CH_DASH, CH_DASH,
                   LEAD_C3, SHARP_S, LEAD_C3, 8'h97, CH_SLASH, CH_DOT, NUL, 8'hFF, LEAD_C3};
        send_name();
        // Curly quote cut short by the end of the name; nothing survives
        name_q = '{LEAD_E2, PUNCT_80};
        send_name();
    endtask

    // Sanitize mode under each separator setting
    task automatic test_separator_modes();
        logic [1:0] modes [4];
        int         m;
        modes = '{SEP_DASH, SEP_NONE, SEP_UNDERSCORE, SEP_SPACE};
        set_reg(REG_SANITIZE_ENABLE, 2'd1);
        for (m = 0; m < 4; m++) begin
            set_reg(REG_SEPARATOR_MODE, modes[m]);
            run_names(20);
        end
    endtask

    // Plain mode: bytes pass through, only the space is mapped or dropped
    task automatic test_plain_mode();
        int m;
        set_reg(REG_SANITIZE_ENABLE, 2'd0);
        for (m = 3; m >= 0; m--) begin
            set_reg(REG_SEPARATOR_MODE, 2'(m));
            run_names(9);
        end
    endtask

    // Writes to unused indexes must leave both registers alone
    task automatic test_unused_index();
        set_reg(REG_SPARE_2, 2'd1);
        set_reg(REG_SPARE_3, 2'd3);
        run_names(8);
    endtask

    task automatic test_random_settings();
        int p;
        for (p = 0; p < 4; p++) begin
            set_reg(REG_SANITIZE_ENABLE, 2'($urandom_range(0, 1)));
            set_reg(REG_SEPARATOR_MODE, 2'($urandom_range(0, 3)));
            run_names(12);
        end
    endtask

    // Full rate on both channels to close out the run
    task automatic test_back_to_back();
        idle_on = 1'b0;
        set_reg(REG_SANITIZE_ENABLE, 2'd1);
        set_reg(REG_SEPARATOR_MODE, 2'($urandom_range(0, 3)));
        run_names(20);
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        rst_n            <= 1'b0;
        wr_en            <= 1'b0;
        wr_index         <= '0;
        wr_data          <= '0;
        name_if.valid    <= 1'b0;
        name_if.in_byte  <= '0;
        name_if.name_end <= 1'b0;

        cfg_san       = 1'b0;
        cfg_mode      = SEP_DASH;
        held_count    = 0;
        prev_was_sep  = 1'b1;
        sep_owed      = 1'b0;
        idle_on       = 1'b1;
        mismatches    = 0;
        bytes_sent    = 0;
        names_sent    = 0;
        slugs_checked = 0;
        reg_writes    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_sanitize_directed();
        test_separator_modes();
        test_plain_mode();
        test_unused_index();
        test_random_settings();
        test_back_to_back();

        drain();
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (exp_slug_q.size() != 0)
            flag_mismatch($sformatf("%0d slug transfers never arrived", exp_slug_q.size()));

        $display("tb: %0d name bytes in %0d names, %0d slug transfers checked",
                 bytes_sent, names_sent, slugs_checked);
        $display("tb: %0d register writes over plain and sanitize modes, all four separators",
                 reg_writes);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
